// File: rtl/text_console_writer_defines.svh
// assertion macros shared by the text console rtl
// no dependencies; included by the files that carry concurrent checks
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define TCW_CHECK_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is high
`define TCW_CHECK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/tcw_pkg.sv
// types and constants of the text console writer
// no dependencies; imported by the interface users, controller and top level
package tcw_pkg;

  // operation codes carried in the func field
  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NOP   = 2'd3
  } tcw_func_t;

  localparam logic [7:0] SPACE_CODE   = 8'h20;
  localparam logic [7:0] NEWLINE_CODE = 8'h0A;
  localparam logic [7:0] COLOR_RESET  = 8'h07;

  // request transaction
  typedef struct packed {
    logic [1:0] func;
    logic [7:0] char_code;
    logic [6:0] read_col;
    logic [4:0] read_row;
  } tcw_req_t;

  // response transaction
  typedef struct packed {
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
  } tcw_rsp_t;

  // strobes from the controller to the cell store
  typedef struct packed {
    logic char_we;
    logic attr_we;
    logic rd_en;
  } tcw_mem_ctl_t;

endpackage

// File: rtl/tcw_chan_if.sv
// valid/ready channel carrying one payload per transaction
// payload type is a parameter; no package dependency
interface tcw_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/tcw_store.sv
// character and attribute cell memories, one shared address port each
// depends on tcw_pkg for the control strobe struct
module tcw_store #(
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                clk,
  input  tcw_pkg::tcw_mem_ctl_t ctl,
  input  logic [AW-1:0]       char_addr,
  input  logic [AW-1:0]       attr_addr,
  input  logic [7:0]          char_wdata,
  input  logic [7:0]          attr_wdata,
  output logic [7:0]          char_rdata,
  output logic [7:0]          attr_rdata
);

  logic [7:0] char_mem [DEPTH];
  logic [7:0] attr_mem [DEPTH];

  // character memory, registered read
  always_ff @(posedge clk) begin
    if (ctl.char_we) begin
      char_mem[char_addr] <= char_wdata;
    end
    if (ctl.rd_en) begin
      char_rdata <= char_mem[char_addr];
    end
  end

  // attribute memory, registered read
  always_ff @(posedge clk) begin
    if (ctl.attr_we) begin
      attr_mem[attr_addr] <= attr_wdata;
    end
    if (ctl.rd_en) begin
      attr_rdata <= attr_mem[attr_addr];
    end
  end

endmodule

// File: rtl/tcw_ctrl.sv
// cursor, scroll offset and operation sequencer of the text console
// depends on tcw_pkg, tcw_chan_if and the assertion macro header
`include "text_console_writer_defines.svh"

module tcw_ctrl #(
  parameter int COLS = 80,
  parameter int ROWS = 25,
  localparam int AW = $clog2(COLS * ROWS)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [7:0]            cfg_wdata,
  tcw_chan_if.sink              req,
  tcw_chan_if.source            rsp,
  output tcw_pkg::tcw_mem_ctl_t mem_ctl,
  output logic [AW-1:0]         char_addr,
  output logic [AW-1:0]         attr_addr,
  output logic [7:0]            char_wdata,
  output logic [7:0]            attr_wdata,
  input  logic [7:0]            char_rdata,
  input  logic [7:0]            attr_rdata
);
  import tcw_pkg::*;

  localparam int CELLS = COLS * ROWS;
  localparam int CW = $clog2(COLS);
  localparam int RW = $clog2(ROWS);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] LAST_COL_A = AW'(COLS - 1);
  localparam logic [AW-1:0] COLS_A = AW'(COLS);
  localparam logic [CW-1:0] LAST_COL = CW'(COLS - 1);
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
  localparam logic [RW:0] ROWS_W = (RW + 1)'(ROWS);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_CLEAR,
    ST_FINISH
  } state_t;

  state_t        state, state_next;
  logic [AW-1:0] cnt, cnt_next;
  logic [CW-1:0] cur_col, cur_col_next;
  logic [RW-1:0] cur_row, cur_row_next;
  logic [RW-1:0] base, base_next;
  logic [7:0]    text_color;
  tcw_req_t      item, item_next;
  logic          rd_hit, rd_hit_next;
  logic          rsp_valid, rsp_valid_next;
  tcw_rsp_t      rsp_data, rsp_data_next;

  logic          read_ok;
  logic [CW-1:0] rd_col;
  logic [RW-1:0] rd_row;
  logic          row_inc;

  // logical screen row to physical character row (rows rotate on scroll)
  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] lrow,
                                             input logic [RW-1:0] b);
    logic [RW:0] sum;
    sum = {1'b0, lrow} + {1'b0, b};
    if (sum >= ROWS_W) begin
      sum = sum - ROWS_W;
    end
    return sum[RW-1:0];
  endfunction

  // row and column to linear cell address
  function automatic logic [AW-1:0] lin(input logic [RW-1:0] row,
                                        input logic [CW-1:0] col);
    return AW'(row) * COLS_A + AW'(col);
  endfunction

  // read coordinates and range check
  assign read_ok = ({1'b0, item.read_col} < 8'(COLS)) && ({2'b0, item.read_row} < 7'(ROWS));
  assign rd_col  = CW'(item.read_col);
  assign rd_row  = RW'(item.read_row);

  assign req.ready  = (state == ST_IDLE);
  assign rsp.valid  = rsp_valid;
  assign rsp.data   = rsp_data;

  // sequencer next state and memory access
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    cur_col_next   = cur_col;
    cur_row_next   = cur_row;
    base_next      = base;
    item_next      = item;
    rd_hit_next    = rd_hit;
    rsp_valid_next = rsp_valid && !rsp.ready;
    rsp_data_next  = rsp_data;
    row_inc        = 1'b0;
    mem_ctl        = '0;
    char_addr      = lin(phys_row(cur_row, base), cur_col);
    attr_addr      = lin(cur_row, cur_col);
    char_wdata     = item.char_code;
    attr_wdata     = text_color;

    case (state)
      ST_INIT: begin
        mem_ctl.char_we = 1'b1;
        mem_ctl.attr_we = 1'b1;
        char_addr       = cnt;
        attr_addr       = cnt;
        char_wdata      = SPACE_CODE;
        attr_wdata      = '0;
        if (cnt == LAST_CELL) begin
          cnt_next   = '0;
          state_next = ST_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      ST_IDLE: begin
        if (req.valid) begin
          item_next  = req.data;
          state_next = ST_EXEC;
        end
      end

      ST_EXEC: begin
        rd_hit_next = 1'b0;
        state_next  = ST_FINISH;
        case (item.func)
          FUNC_WRITE: begin
            if (item.char_code == NEWLINE_CODE) begin
              cur_col_next = '0;
              row_inc      = 1'b1;
            end else begin
              mem_ctl.char_we = 1'b1;
              mem_ctl.attr_we = 1'b1;
              if (cur_col == LAST_COL) begin
                cur_col_next = '0;
                row_inc      = 1'b1;
              end else begin
                cur_col_next = cur_col + 1'b1;
              end
            end
            if (row_inc) begin
              if (cur_row == LAST_ROW) begin
                cnt_next   = '0;
                state_next = ST_SCROLL;
              end else begin
                cur_row_next = cur_row + 1'b1;
              end
            end
          end
          FUNC_CLEAR: begin
            cnt_next   = '0;
            state_next = ST_CLEAR;
          end
          FUNC_READ: begin
            if (read_ok) begin
              mem_ctl.rd_en = 1'b1;
              char_addr     = lin(phys_row(rd_row, base), rd_col);
              attr_addr     = lin(rd_row, rd_col);
              rd_hit_next   = 1'b1;
            end
          end
          default: begin
            state_next = ST_FINISH;
          end
        endcase
      end

      // blank the oldest physical row, which becomes the new bottom row
      ST_SCROLL: begin
        mem_ctl.char_we = 1'b1;
        char_addr       = lin(base, CW'(cnt));
        char_wdata      = SPACE_CODE;
        if (cnt == LAST_COL_A) begin
          cnt_next   = '0;
          base_next  = (base == LAST_ROW) ? '0 : base + 1'b1;
          state_next = ST_FINISH;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      ST_CLEAR: begin
        mem_ctl.char_we = 1'b1;
        mem_ctl.attr_we = 1'b1;
        char_addr       = cnt;
        attr_addr       = cnt;
        char_wdata      = SPACE_CODE;
        if (cnt == LAST_CELL) begin
          cnt_next     = '0;
          cur_col_next = '0;
          cur_row_next = '0;
          base_next    = '0;
          state_next   = ST_FINISH;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      ST_FINISH: begin
        if (!rsp_valid || rsp.ready) begin
          rsp_valid_next           = 1'b1;
          rsp_data_next.cursor_col = 7'(cur_col);
          rsp_data_next.cursor_row = 5'(cur_row);
          rsp_data_next.cell_char  = rd_hit ? char_rdata : 8'h00;
          rsp_data_next.cell_attr  = rd_hit ? attr_rdata : 8'h00;
          state_next               = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

  // state, cursor and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      cnt       <= '0;
      cur_col   <= '0;
      cur_row   <= '0;
      base      <= '0;
      rd_hit    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      cur_col   <= cur_col_next;
      cur_row   <= cur_row_next;
      base      <= base_next;
      rd_hit    <= rd_hit_next;
      rsp_valid <= rsp_valid_next;
    end
    item     <= item_next;
    rsp_data <= rsp_data_next;
  end

  // colour register
  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= COLOR_RESET;
    end else if (cfg_we) begin
      text_color <= cfg_wdata;
    end
  end

  // checks
  `TCW_CHECK_NOW(a_cursor_on_screen, clk, rst, 1'b1, (cur_col <= LAST_COL) && (cur_row <= LAST_ROW), "cursor off screen")
  `TCW_CHECK_NOW(a_base_in_range, clk, rst, 1'b1, base <= LAST_ROW, "scroll offset out of range")
  `TCW_CHECK_NEXT(a_accept_executes, clk, rst, req.valid && req.ready, state == ST_EXEC, "accepted transaction not executed")
  `TCW_CHECK_NOW(a_quiet_memory, clk, rst, (state == ST_IDLE) || (state == ST_FINISH), !mem_ctl.char_we && !mem_ctl.attr_we && !mem_ctl.rd_en, "memory access outside a pass")
  `TCW_CHECK_NEXT(a_read_lands, clk, rst, mem_ctl.rd_en, (state == ST_FINISH) && rd_hit, "cell read not returned")

endmodule

// File: rtl/text_console_writer.sv
// Text console with a COLS x ROWS cell store held in two single-port memories (character and
// attribute) and a cursor. A write, newline or read is accepted in the idle state, does its
// memory access in the execute state and has its result registered in the finish state once
// the output register is free; a new request is taken while an earlier result still waits
// there. A newline or wrap past the bottom row first blanks one character row, since rows
// rotate through a scroll offset and one cell is written per cycle. A clear-screen writes every
// cell (2000 by default) in one-cell-a-cycle writes. After reset the store is swept the same
// way, during which no request is accepted; colour writes on cfg_we are taken at any time.
// depends on tcw_pkg, tcw_chan_if, tcw_ctrl and tcw_store
module text_console_writer #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  tcw_chan_if.sink   req,
  tcw_chan_if.source rsp
);
  import tcw_pkg::*;

  localparam int CELLS = COLS * ROWS;
  localparam int AW = $clog2(CELLS);

  tcw_mem_ctl_t  mem_ctl;
  logic [AW-1:0] char_addr;
  logic [AW-1:0] attr_addr;
  logic [7:0]    char_wdata;
  logic [7:0]    attr_wdata;
  logic [7:0]    char_rdata;
  logic [7:0]    attr_rdata;

  // sequencer and cursor
  tcw_ctrl #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .rsp       (rsp),
    .mem_ctl   (mem_ctl),
    .char_addr (char_addr),
    .attr_addr (attr_addr),
    .char_wdata(char_wdata),
    .attr_wdata(attr_wdata),
    .char_rdata(char_rdata),
    .attr_rdata(attr_rdata)
  );

  // cell memories
  tcw_store #(
    .DEPTH(CELLS)
  ) u_store (
    .clk       (clk),
    .ctl       (mem_ctl),
    .char_addr (char_addr),
    .attr_addr (attr_addr),
    .char_wdata(char_wdata),
    .attr_wdata(attr_wdata),
    .char_rdata(char_rdata),
    .attr_rdata(attr_rdata)
  );

endmodule
